FILE: rtl/core/mgrs_pkg.sv
// ----------------------------------------------------------------------------
// Motion-gated report scheduler package
// Item layouts, configuration and state records, command and register codes,
// and reset values shared by the scheduler modules.
// ----------------------------------------------------------------------------
package mgrs_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WAKE  = 2'd1;
  localparam logic [1:0] CMD_LEAVE = 2'd2;

  // Mode change codes carried in a result item.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_STOP = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_THRESH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_THRESH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_HOLD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_PERIOD   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_PERIOD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HB_PERIOD    = 3'd5;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] RST_WAKE_THRESH = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_RUN_THRESH  = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_RUN_HOLD    = 16'd180;
  localparam logic [CFG_DATA_W-1:0] RST_RUN_PERIOD  = 16'd30;
  localparam logic [CFG_DATA_W-1:0] RST_STOP_PERIOD = 16'd3600;
  localparam logic [CFG_DATA_W-1:0] RST_HB_PERIOD   = 16'd300;

  // Input item.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] now_seconds;
    logic [15:0]       motion_level;
    logic              ignition_on;
  } req_t;

  // Result item.
  typedef struct packed {
    logic       record_and_upload;
    logic       heartbeat;
    logic       wake_request;
    logic [1:0] mode_change;
    logic       in_run_mode;
    logic       is_working;
  } rsp_t;

  // Configuration registers.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] wake_motion_threshold;
    logic [CFG_DATA_W-1:0] run_motion_threshold;
    logic [CFG_DATA_W-1:0] run_hold_seconds;
    logic [CFG_DATA_W-1:0] run_report_period;
    logic [CFG_DATA_W-1:0] stop_report_period;
    logic [CFG_DATA_W-1:0] heartbeat_period;
  } cfg_t;

  // Scheduler state.
  typedef struct packed {
    logic              working;
    logic              wake_latched;
    logic              run_mode;
    logic [TIME_W-1:0] run_deadline;
    logic [TIME_W-1:0] record_deadline;
    logic [TIME_W-1:0] heartbeat_deadline;
  } state_t;

endpackage

FILE: rtl/core/mgrs_step.sv
// ----------------------------------------------------------------------------
// Motion-gated report scheduler step logic
// Computes the next scheduler state and the result item for one input item.
// ----------------------------------------------------------------------------
module mgrs_step (
  input  mgrs_pkg::cfg_t   cfg,
  input  mgrs_pkg::state_t state,
  input  mgrs_pkg::req_t   item,
  output mgrs_pkg::state_t state_next,
  output mgrs_pkg::rsp_t   result
);
  import mgrs_pkg::*;

  logic              wake_hit;
  logic              renew;
  logic [TIME_W-1:0] now_plus_hold;
  logic [TIME_W-1:0] now_plus_run;
  logic [TIME_W-1:0] now_plus_stop;
  logic [TIME_W-1:0] now_plus_hb;
  logic [TIME_W-1:0] run_dl;
  logic [TIME_W-1:0] rec_dl;
  logic              run_mode_w;
  logic [1:0]        mode_chg;
  logic              rec_due;
  logic              hb_due;

  // Wake condition: motion threshold, or the ignition line when it is zero.
  assign wake_hit = (cfg.wake_motion_threshold != '0)
                  ? (item.motion_level >= cfg.wake_motion_threshold)
                  : item.ignition_on;

  assign renew = (cfg.run_motion_threshold == '0) ||
                 (item.motion_level >= cfg.run_motion_threshold);

  // All candidate deadlines are formed in parallel; sums wrap at 32 bits.
  assign now_plus_hold = item.now_seconds + {16'd0, cfg.run_hold_seconds};
  assign now_plus_run  = item.now_seconds + {16'd0, cfg.run_report_period};
  assign now_plus_stop = item.now_seconds + {16'd0, cfg.stop_report_period};
  assign now_plus_hb   = item.now_seconds + {16'd0, cfg.heartbeat_period};

  // Working-state tick: run renewal, mode switch and record deadline.
  always_comb begin
    run_dl     = renew ? now_plus_hold : state.run_deadline;
    run_mode_w = state.run_mode;
    mode_chg   = MODE_NONE;
    rec_dl     = state.record_deadline;
    if (item.now_seconds > run_dl) begin
      if (state.run_mode) begin
        run_mode_w = 1'b0;
        mode_chg   = MODE_STOP;
      end
    end else if (!state.run_mode) begin
      run_mode_w = 1'b1;
      mode_chg   = MODE_RUN;
      if (state.record_deadline > {16'd0, cfg.stop_report_period}) begin
        rec_dl = item.now_seconds;
      end else begin
        rec_dl = now_plus_run;
      end
    end
  end

  assign rec_due = item.now_seconds >= rec_dl;
  assign hb_due  = item.now_seconds >= state.heartbeat_deadline;

  // Next state and result by command.
  always_comb begin
    state_next = state;
    result     = '0;
    case (item.cmd)
      CMD_TICK: begin
        state_next.wake_latched = state.wake_latched | wake_hit;
        if (state.working) begin
          state_next.run_deadline = run_dl;
          state_next.run_mode     = run_mode_w;
          result.mode_change      = mode_chg;
          state_next.record_deadline = rec_dl;
          if (rec_due) begin
            result.record_and_upload   = 1'b1;
            state_next.record_deadline = run_mode_w ? now_plus_run : now_plus_stop;
          end
          if (hb_due) begin
            result.heartbeat              = 1'b1;
            state_next.heartbeat_deadline = now_plus_hb;
          end
        end else begin
          state_next.run_deadline = now_plus_hold;
          if (state.wake_latched | wake_hit) begin
            state_next.working  = 1'b1;
            result.wake_request = 1'b1;
          end
        end
      end
      CMD_WAKE: begin
        state_next.working  = 1'b1;
        result.wake_request = 1'b1;
      end
      CMD_LEAVE: begin
        state_next.working      = 1'b0;
        state_next.wake_latched = 1'b0;
      end
      default: begin
        state_next = state;
      end
    endcase
    result.in_run_mode = state_next.run_mode;
    result.is_working  = state_next.working;
  end

endmodule

FILE: rtl/core/motion_gated_report_scheduler.sv
// ----------------------------------------------------------------------------
// Motion-gated report scheduler
// Wakes on motion or ignition, tracks run and stop mode, and schedules
// record-and-upload events and heartbeats from time ticks.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item. The block takes one item
// per clock cycle while req_stall is low. An item waits in the input register
// while the step logic works on it, and the result register loads the result
// as the item leaves. Scheduler state is updated as an item leaves the input
// register, so consecutive items see each other's effects without gaps. A
// stalled result holds the result register. The input register still takes
// one further item, and then req_stall rises. Configuration writes are
// registered and should be made only while no item is in flight.
module motion_gated_report_scheduler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  mgrs_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output mgrs_pkg::rsp_t                       rsp,
  input  logic                                 cfg_we,
  input  logic [mgrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mgrs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mgrs_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  rsp_t   result;
  logic   pipe_valid;
  req_t   pipe_item;
  logic   advance;

  // An item in the input register moves on when the result register is free.
  assign advance   = pipe_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = pipe_valid && !advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_motion_threshold <= RST_WAKE_THRESH;
      cfg.run_motion_threshold  <= RST_RUN_THRESH;
      cfg.run_hold_seconds      <= RST_RUN_HOLD;
      cfg.run_report_period     <= RST_RUN_PERIOD;
      cfg.stop_report_period    <= RST_STOP_PERIOD;
      cfg.heartbeat_period      <= RST_HB_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAKE_THRESH: cfg.wake_motion_threshold <= cfg_data;
        REG_RUN_THRESH:  cfg.run_motion_threshold  <= cfg_data;
        REG_RUN_HOLD:    cfg.run_hold_seconds      <= cfg_data;
        REG_RUN_PERIOD:  cfg.run_report_period     <= cfg_data;
        REG_STOP_PERIOD: cfg.stop_report_period    <= cfg_data;
        REG_HB_PERIOD:   cfg.heartbeat_period      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (!req_stall) begin
      pipe_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      pipe_item <= req;
    end
  end

  // Step logic.
  mgrs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (pipe_item),
    .state_next (state_next),
    .result     (result)
  );

  // Scheduler state, updated as each item passes the step logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.working            <= 1'b0;
      state.wake_latched       <= 1'b0;
      state.run_mode           <= 1'b1;
      state.run_deadline       <= {16'd0, RST_RUN_HOLD};
      state.record_deadline    <= '0;
      state.heartbeat_deadline <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  // A wake request always leaves the block working.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.wake_request || rsp.is_working))
    else $error("wake request without working flag");

  // Mode change codes agree with the reported mode.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.mode_change != MODE_RUN || rsp.in_run_mode) &&
                   (rsp.mode_change != MODE_STOP || !rsp.in_run_mode)))
    else $error("mode change disagrees with run mode flag");

  // Records and heartbeats come only from a working block.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.record_and_upload || rsp.heartbeat)) |-> rsp.is_working)
    else $error("event issued while not working");

  // A leave command clears the working flag and the wake latch.
  assert property (@(posedge clk) disable iff (rst)
    (advance && pipe_item.cmd == CMD_LEAVE) |=> (!state.working && !state.wake_latched))
    else $error("leave command did not clear working state");

  // The reported flags track the state written with the result.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (rsp.is_working == state.working && rsp.in_run_mode == state.run_mode))
    else $error("result flags disagree with scheduler state");

endmodule

FILE: dv/tb_motion_gated_report_scheduler.sv
// ----------------------------------------------------------------------------
// Motion-gated report scheduler testbench
// Drives ticks, wakes and leave commands through the valid/stall request
// channel and predicts every result item with a behavioral copy of the
// scheduler. It checks each result field by field across several register
// settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_motion_gated_report_scheduler;
  import mgrs_pkg::*;

  // The spare command code has no meaning and must leave the state alone.
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 170;

  // Expected result items and the predicted scheduler state behind them.
  class report_scoreboard;
    cfg_t   regs;
    state_t st;
    rsp_t   due_reports[$];
    int     failures;

    function new();
      regs = {RST_WAKE_THRESH, RST_RUN_THRESH, RST_RUN_HOLD,
              RST_RUN_PERIOD, RST_STOP_PERIOD, RST_HB_PERIOD};
      st = '0;
      st.run_mode = 1'b1;
      st.run_deadline = {16'd0, RST_RUN_HOLD};
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_WAKE_THRESH: regs.wake_motion_threshold = val;
        REG_RUN_THRESH:  regs.run_motion_threshold = val;
        REG_RUN_HOLD:    regs.run_hold_seconds = val;
        REG_RUN_PERIOD:  regs.run_report_period = val;
        REG_STOP_PERIOD: regs.stop_report_period = val;
        REG_HB_PERIOD:   regs.heartbeat_period = val;
        default: ;
      endcase
    endfunction

    // Advance the predicted scheduler by one item and return its result.
    function rsp_t schedule_step(req_t r);
      rsp_t o;
      o = '0;
      case (r.cmd)
        CMD_TICK: begin
          // The wake condition only ever sets the latch, in any state.
          if (regs.wake_motion_threshold != '0) begin
            if (r.motion_level >= regs.wake_motion_threshold) st.wake_latched = 1'b1;
          end else if (r.ignition_on) begin
            st.wake_latched = 1'b1;
          end
          if (st.working) begin
            if (regs.run_motion_threshold == '0 ||
                r.motion_level >= regs.run_motion_threshold) begin
              st.run_deadline = r.now_seconds + {16'd0, regs.run_hold_seconds};
            end
            if (r.now_seconds > st.run_deadline) begin
              if (st.run_mode) begin
                st.run_mode = 1'b0;
                o.mode_change = MODE_STOP;
              end
            end else if (!st.run_mode) begin
              st.run_mode = 1'b1;
              o.mode_change = MODE_RUN;
              if (st.record_deadline > {16'd0, regs.stop_report_period}) begin
                st.record_deadline = r.now_seconds;
              end else begin
                st.record_deadline = r.now_seconds + {16'd0, regs.run_report_period};
              end
            end
            if (r.now_seconds >= st.record_deadline) begin
              o.record_and_upload = 1'b1;
              st.record_deadline = r.now_seconds + {16'd0, st.run_mode ?
                regs.run_report_period : regs.stop_report_period};
            end
            if (r.now_seconds >= st.heartbeat_deadline) begin
              o.heartbeat = 1'b1;
              st.heartbeat_deadline = r.now_seconds + {16'd0, regs.heartbeat_period};
            end
          end else begin
            st.run_deadline = r.now_seconds + {16'd0, regs.run_hold_seconds};
            if (st.wake_latched) begin
              st.working = 1'b1;
              o.wake_request = 1'b1;
            end
          end
        end
        CMD_WAKE: begin
          st.working = 1'b1;
          o.wake_request = 1'b1;
        end
        CMD_LEAVE: begin
          st.working = 1'b0;
          st.wake_latched = 1'b0;
        end
        default: ;
      endcase
      o.in_run_mode = st.run_mode;
      o.is_working = st.working;
      return o;
    endfunction

    function void note_item(req_t r);
      due_reports.push_back(schedule_step(r));
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(rsp_t got);
      rsp_t want;
      if (due_reports.size() == 0) begin
        $error("result item arrived with no expected item pending");
        failures++;
        return;
      end
      want = due_reports.pop_front();
      check_field("record_and_upload", 2'(want.record_and_upload),
                  2'(got.record_and_upload));
      check_field("heartbeat", 2'(want.heartbeat), 2'(got.heartbeat));
      check_field("wake_request", 2'(want.wake_request), 2'(got.wake_request));
      check_field("mode_change", want.mode_change, got.mode_change);
      check_field("in_run_mode", 2'(want.in_run_mode), 2'(got.in_run_mode));
      check_field("is_working", 2'(want.is_working), 2'(got.is_working));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_WAKE_THRESH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  report_scoreboard sb = new();
  int               gap_pct = 0;
  int               stall_pct = 0;
  int               step_max = 10;
  int               cycle_count = 0;
  logic [31:0]      tick_now = '0;

  motion_gated_report_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Record every accepted input item.
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_item(req);
  end

  // Check accepted result items and stall the result channel at random.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_report(rsp);
    rsp_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Select how often the sender idles and the receiver stalls.
  task automatic set_idling(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 71; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 71; end
      default: begin gap_pct = 17; stall_pct = 17; end
    endcase
  endtask

  // Present one item, after a random gap, and hold it until it is taken.
  task automatic send_item(input logic [1:0] c, input logic [31:0] n,
                           input logic [15:0] m, input logic ign);
    req_t item;
    item.cmd = c;
    item.now_seconds = n;
    item.motion_level = m;
    item.ignition_on = ign;
    if ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Hold off the sender until every expected result has been checked.
  task automatic drain_reports();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Program all six registers and pick a time step that suits them.
  task automatic write_cfg(input cfg_t c);
    put_reg(REG_WAKE_THRESH, c.wake_motion_threshold);
    put_reg(REG_RUN_THRESH, c.run_motion_threshold);
    put_reg(REG_RUN_HOLD, c.run_hold_seconds);
    put_reg(REG_RUN_PERIOD, c.run_report_period);
    put_reg(REG_STOP_PERIOD, c.stop_report_period);
    put_reg(REG_HB_PERIOD, c.heartbeat_period);
    cfg_we <= 1'b0;
    @(posedge clk);
    step_max = (int'(c.run_hold_seconds) + int'(c.run_report_period) +
                int'(c.heartbeat_period)) / 6 + 3;
  endtask

  // Register settings for each random phase, extremes included.
  function automatic cfg_t make_cfg(input int kind);
    cfg_t c;
    c.wake_motion_threshold = 16'($urandom_range(1, 300));
    c.run_motion_threshold = 16'($urandom_range(1, 300));
    c.run_hold_seconds = 16'($urandom_range(0, 20));
    c.run_report_period = 16'($urandom_range(0, 10));
    c.stop_report_period = 16'($urandom_range(0, 40));
    c.heartbeat_period = 16'($urandom_range(0, 15));
    case (kind)
      0: c = {RST_WAKE_THRESH, RST_RUN_THRESH, RST_RUN_HOLD,
              RST_RUN_PERIOD, RST_STOP_PERIOD, RST_HB_PERIOD};
      1: c = '0;
      2: c = '1;
      4: c = {$urandom(), $urandom(), $urandom()};
      5: c.wake_motion_threshold = '0;
      6: begin
        c.wake_motion_threshold = '1;
        c.run_motion_threshold = '1;
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    int          ph;
    int          k;
    int          pick;
    int          level;
    logic [1:0]  c;
    logic [15:0] m;
    logic [15:0] thr;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the reset settings: ignition selects the wake.
    send_item(CMD_TICK, 32'd0, 16'd0, 1'b0);
    send_item(CMD_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(CMD_LEAVE, 32'd0, 16'd0, 1'b0);
    send_item(CMD_TICK, 32'd5, 16'd0, 1'b1);
    send_item(CMD_TICK, 32'd5, 16'd0, 1'b0);
    send_item(CMD_TICK, 32'd36, 16'd0, 1'b0);
    send_item(CMD_WAKE, 32'd0, 16'd0, 1'b0);
    send_item(CMD_LEAVE, 32'd0, 16'd0, 1'b0);
    // After a leave the stale latch must not wake the block again.
    send_item(CMD_TICK, 32'd40, 16'd0, 1'b0);
    send_item(CMD_WAKE, 32'd0, 16'd0, 1'b0);

    // Directed items with motion thresholds and short periods.
    drain_reports();
    write_cfg({16'd100, 16'd50, 16'd10, 16'd5, 16'd20, 16'd7});
    send_item(CMD_TICK, 32'd50, 16'd50, 1'b0);
    send_item(CMD_TICK, 32'd61, 16'd0, 1'b0);
    send_item(CMD_TICK, 32'd70, 16'd49, 1'b0);
    send_item(CMD_TICK, 32'd71, 16'd50, 1'b0);
    // The renewed run deadline wraps past zero here.
    send_item(CMD_TICK, 32'hFFFF_FFF8, 16'hFFFF, 1'b1);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send_item(CMD_TICK, 32'd1, 16'd0, 1'b0);
    send_item(CMD_LEAVE, 32'd0, 16'd0, 1'b0);
    send_item(CMD_TICK, 32'd2, 16'd99, 1'b1);
    send_item(CMD_TICK, 32'd3, 16'd100, 1'b0);
    tick_now = 32'd3;

    // Random phases, each under its own settings and idling pattern.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_reports();
      write_cfg(make_cfg(ph));
      set_idling(ph % 4);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) set_idling((ph + 1) % 4);

        // Mostly ticks; an idle block is woken often so the run logic is reached.
        pick = $urandom_range(99);
        if (!sb.st.working && pick < 25) c = CMD_WAKE;
        else if (pick < 4) c = CMD_LEAVE;
        else if (pick < 8) c = CMD_WAKE;
        else if (pick < 10) c = CMD_SPARE;
        else c = CMD_TICK;

        // Time mostly creeps forward, with jumps, steps back and wraps.
        if (c == CMD_TICK) begin
          pick = $urandom_range(99);
          if (pick < 70) tick_now += $urandom_range(0, step_max);
          else if (pick < 85) tick_now += $urandom_range(0, 2);
          else if (pick < 90) tick_now += $urandom_range(0, 70000);
          else if (pick < 94) tick_now -= $urandom_range(1, 5);
          else if (pick < 97) tick_now = $urandom();
          else tick_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
        end

        // Motion sits at zero, right around a threshold, or anywhere.
        pick = $urandom_range(99);
        if (pick < 35) begin
          m = '0;
        end else if (pick < 65) begin
          thr = $urandom_range(0, 1) ? sb.regs.wake_motion_threshold :
                                       sb.regs.run_motion_threshold;
          level = int'(thr) + int'($urandom_range(0, 2)) - 1;
          if (level < 0) level = 0;
          if (level > 65535) level = 65535;
          m = level[15:0];
        end else begin
          m = 16'($urandom_range(0, 65535));
        end

        send_item(c, (c == CMD_TICK) ? tick_now : $urandom(), m,
                  1'($urandom_range(0, 1)));
      end
    end

    drain_reports();
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
